### rtl/core/adpcm_block_sample_decoder_assert.svh
// Assertion macros used by the ADPCM decoder checker.
`ifndef ADPCM_BLOCK_SAMPLE_DECODER_ASSERT_SVH
`define ADPCM_BLOCK_SAMPLE_DECODER_ASSERT_SVH

// Generic clocked assertion, disabled during reset.
`define ADPCM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication.
`define ADPCM_ASSERT_IMPL(label, ante, cons, msg) \
   `ADPCM_ASSERT(label, ante |-> cons, msg)

// Next-cycle implication.
`define ADPCM_ASSERT_NEXT(label, ante, cons, msg) \
   `ADPCM_ASSERT(label, ante |=> cons, msg)

`endif

### rtl/core/adpcm_dec_pkg.sv
// Types, constants and coefficient tables for the ADPCM block decoder.
package adpcm_dec_pkg;

   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned COEF_W    = 7;
   localparam int unsigned ACC_W     = 24;
   localparam int unsigned FRAC_BITS = 6;
   localparam int unsigned PRED_W    = ACC_W - FRAC_BITS;
   localparam int unsigned SUM_W     = PRED_W + 1;
   localparam int unsigned NIB_W     = 4;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned FILT_W    = 3;

   localparam logic [NIB_W-1:0]  SHIFT_MAX   = 4'd12;
   localparam logic [NIB_W-1:0]  SHIFT_CLAMP = 4'd9;
   localparam logic [FILT_W-1:0] FILT_MAX    = 3'd4;
   localparam logic [FILT_W-1:0] FILT_NONE   = 3'd0;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 24'sd32;
   localparam logic signed [ACC_W-1:0] TRUNC_FIX  = 24'sd63;

   localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
   localparam logic [POS_W-1:0] POS_FLAG   = 4'd1;
   localparam logic [POS_W-1:0] POS_LAST   = 4'd15;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [COEF_W-1:0]          coef_type;

   typedef enum logic [1:0] {
      MAC_HOLD = 2'd0,
      MAC_LOAD = 2'd1,
      MAC_SUB  = 2'd2
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      coef_type   coef;
      sample_type operand;
   } mac_cmd_type;

   function automatic coef_type coef_prev(input logic [FILT_W-1:0] filt);
      coef_type k;
      case (filt)
         3'd1:    k = 7'd60;
         3'd2:    k = 7'd115;
         3'd3:    k = 7'd98;
         3'd4:    k = 7'd122;
         default: k = 7'd0;
      endcase
      return k;
   endfunction

   function automatic coef_type coef_older(input logic [FILT_W-1:0] filt);
      coef_type k;
      case (filt)
         3'd2:    k = 7'd52;
         3'd3:    k = 7'd55;
         3'd4:    k = 7'd60;
         default: k = 7'd0;
      endcase
      return k;
   endfunction

endpackage

### rtl/core/adpcm_dec_if.sv
// Valid/ready channel interfaces for the ADPCM decoder byte input and sample output.
interface adpcm_dec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_stream;

   modport source (output valid, output data_byte, output start_stream, input ready);
   modport sink   (input valid, input data_byte, input start_stream, output ready);
endinterface

interface adpcm_dec_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pcm_sample;
   logic               last_of_byte;
   logic               last_of_block;

   modport source (output valid, output pcm_sample, output last_of_byte,
                   output last_of_block, input ready);
   modport sink   (input valid, input pcm_sample, input last_of_byte,
                   input last_of_block, output ready);
endinterface

### rtl/core/adpcm_dec_mac.sv
// Shared multiply-accumulate unit for the prediction filter.
module adpcm_dec_mac (
   input  logic                                      clock,
   input  adpcm_dec_pkg::mac_cmd_type                cmd,
   output logic signed [adpcm_dec_pkg::ACC_W-1:0]    acc
);

   logic signed [adpcm_dec_pkg::ACC_W-1:0] prod;
   logic signed [adpcm_dec_pkg::ACC_W-1:0] acc_ff;
   logic signed [adpcm_dec_pkg::ACC_W-1:0] acc_in;
   logic signed [adpcm_dec_pkg::COEF_W:0]  coef_s;

   assign coef_s = $signed({1'b0, cmd.coef});
   assign prod   = adpcm_dec_pkg::ACC_W'(coef_s * cmd.operand);

   always_comb begin
      case (cmd.op)
         adpcm_dec_pkg::MAC_LOAD: acc_in = adpcm_dec_pkg::ROUND_BIAS + prod;
         adpcm_dec_pkg::MAC_SUB:  acc_in = acc_ff - prod;
         default:                 acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/core/adpcm_block_sample_decoder.sv
// Top level of the streaming ADPCM block sample decoder.
//
// Usage:
//  - req_chan carries one raw byte per beat (data_byte) plus start_stream, which
//    clears sample history and block position ahead of that byte.
//  - Bytes arrive in 16-byte blocks: byte 0 is the shift/filter header, byte 1 is
//    ignored, bytes 2..15 each yield two beats on rsp_chan (low nibble first).
//  - Header and flag bytes produce nothing; the sequencer stays idle for them.
//  - A data byte is accepted while idle, then each sample takes two passes through
//    the one shared multiplier (k0*prev in ST_MUL_A, then k1*older in ST_MUL_B),
//    a round/add/saturate step (ST_SUM) and an output step (ST_OUT).
//  - Each sample feeds the next one's prediction, so samples go strictly one
//    after another; req_chan.ready is high only while the sequencer is idle.
//  - A result beat holds in the output register until the sink takes it; the
//    sequencer waits there, so a stall simply stretches the byte's latency.
//  - Synchronous active-high reset clears history, header fields, position and
//    output valid; the block is ready the first cycle after reset drops.
module adpcm_block_sample_decoder (
   input  logic                   clock,
   input  logic                   reset,
   adpcm_dec_req_if.sink          req_chan,
   adpcm_dec_rsp_if.source        rsp_chan
);

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL_A = 5'b00010,
      ST_MUL_B = 5'b00100,
      ST_SUM   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   localparam int unsigned SW  = adpcm_dec_pkg::SAMPLE_W;
   localparam int unsigned NW  = adpcm_dec_pkg::NIB_W;
   localparam int unsigned PW  = adpcm_dec_pkg::PRED_W;
   localparam int unsigned UW  = adpcm_dec_pkg::SUM_W;
   localparam int unsigned AW  = adpcm_dec_pkg::ACC_W;

   state_type                              state_ff, state_in;
   adpcm_dec_pkg::sample_type              prev_ff, prev_in;
   adpcm_dec_pkg::sample_type              older_ff, older_in;
   logic [NW-1:0]                          shift_ff, shift_in;
   logic [adpcm_dec_pkg::FILT_W-1:0]       filter_ff, filter_in;
   logic [adpcm_dec_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [7:0]                             byte_ff, byte_in;
   logic                                   nib_hi_ff, nib_hi_in;
   logic                                   last_blk_ff, last_blk_in;
   adpcm_dec_pkg::sample_type              sample_ff, sample_in;
   logic                                   rsp_valid_ff, rsp_valid_in;

   logic                                   accept;
   logic [adpcm_dec_pkg::POS_W-1:0]        pos_cur;
   adpcm_dec_pkg::mac_cmd_type             mac_cmd;
   logic signed [AW-1:0]                   acc;
   logic signed [AW-1:0]                   acc_adj;
   logic signed [PW-1:0]                   pred;
   logic [NW-1:0]                          nib;
   adpcm_dec_pkg::sample_type              base;
   logic [NW-1:0]                          base_shamt;
   logic signed [UW-1:0]                   sum;
   adpcm_dec_pkg::sample_type              sat;
   logic [NW-1:0]                          hdr_shift;
   logic [adpcm_dec_pkg::FILT_W-1:0]       hdr_filter;

   adpcm_dec_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .acc   (acc)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;

   // Start flag restarts the block before this byte is classified
   assign pos_cur = req_chan.start_stream ? adpcm_dec_pkg::POS_HEADER : pos_ff;

   assign hdr_shift  = req_chan.data_byte[NW-1:0];
   assign hdr_filter = req_chan.data_byte[NW+adpcm_dec_pkg::FILT_W-1:NW];

   // Multiplier schedule: load k0*prev (+ rounding bias), then subtract k1*older
   always_comb begin
      mac_cmd.op      = adpcm_dec_pkg::MAC_HOLD;
      mac_cmd.coef    = '0;
      mac_cmd.operand = '0;
      case (state_ff)
         ST_MUL_A: begin
            mac_cmd.op      = adpcm_dec_pkg::MAC_LOAD;
            mac_cmd.coef    = adpcm_dec_pkg::coef_prev(filter_ff);
            mac_cmd.operand = prev_ff;
         end
         ST_MUL_B: begin
            mac_cmd.op      = adpcm_dec_pkg::MAC_SUB;
            mac_cmd.coef    = adpcm_dec_pkg::coef_older(filter_ff);
            mac_cmd.operand = older_ff;
         end
         default: begin
            mac_cmd.op = adpcm_dec_pkg::MAC_HOLD;
         end
      endcase
   end

   // Divide by 64 truncating toward zero: bias negatives before the shift
   assign acc_adj = acc[AW-1] ? (acc + adpcm_dec_pkg::TRUNC_FIX) : acc;
   assign pred    = acc_adj[AW-1:adpcm_dec_pkg::FRAC_BITS];

   // Nibble scaled by 2^(12 - shift); shift is always 0..12 once latched
   assign nib        = nib_hi_ff ? byte_ff[2*NW-1:NW] : byte_ff[NW-1:0];
   assign base_shamt = adpcm_dec_pkg::SHIFT_MAX - shift_ff;
   assign base       = $signed({{(SW-NW){nib[NW-1]}}, nib}) <<< base_shamt;

   assign sum = $signed({{(UW-SW){base[SW-1]}}, base})
              + $signed({{(UW-PW){pred[PW-1]}}, pred});

   // Saturate: in range when the sample sign bit and all bits above it agree
   always_comb begin
      if (sum[UW-1:SW-1] == '0 || sum[UW-1:SW-1] == '1) begin
         sat = sum[SW-1:0];
      end else if (sum[UW-1]) begin
         sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      older_in     = older_ff;
      shift_in     = shift_ff;
      filter_in    = filter_ff;
      pos_in       = pos_ff;
      byte_in      = byte_ff;
      nib_hi_in    = nib_hi_ff;
      last_blk_in  = last_blk_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.start_stream) begin
                  prev_in  = '0;
                  older_in = '0;
               end
               pos_in = pos_cur + 1'b1;
               if (pos_cur == adpcm_dec_pkg::POS_HEADER) begin
                  shift_in  = (hdr_shift > adpcm_dec_pkg::SHIFT_MAX) ?
                              adpcm_dec_pkg::SHIFT_CLAMP : hdr_shift;
                  filter_in = (hdr_filter > adpcm_dec_pkg::FILT_MAX) ?
                              adpcm_dec_pkg::FILT_NONE : hdr_filter;
               end else if (pos_cur != adpcm_dec_pkg::POS_FLAG) begin
                  byte_in     = req_chan.data_byte;
                  nib_hi_in   = 1'b0;
                  last_blk_in = (pos_cur == adpcm_dec_pkg::POS_LAST);
                  state_in    = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_SUM;
         ST_SUM: begin
            sample_in    = sat;
            older_in     = prev_ff;
            prev_in      = sat;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (nib_hi_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  nib_hi_in = 1'b1;
                  state_in  = ST_MUL_A;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         older_ff     <= '0;
         shift_ff     <= '0;
         filter_ff    <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         older_ff     <= older_in;
         shift_ff     <= shift_in;
         filter_ff    <= filter_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      nib_hi_ff   <= nib_hi_in;
      last_blk_ff <= last_blk_in;
      sample_ff   <= sample_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pcm_sample    = sample_ff;
   assign rsp_chan.last_of_byte  = nib_hi_ff;
   assign rsp_chan.last_of_block = nib_hi_ff & last_blk_ff;

endmodule

### rtl/core/adpcm_dec_checker.sv
// Port-level checker for the ADPCM decoder, bound to the top level.
`include "adpcm_block_sample_decoder_assert.svh"

module adpcm_dec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] pcm_sample,
   input logic        last_of_byte,
   input logic        last_of_block
);

   `ADPCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(pcm_sample), "rsp beat dropped or changed while stalled")
   `ADPCM_ASSERT_IMPL(a_no_accept_busy, rsp_valid, !req_ready, "input ready while a sample is pending")
   `ADPCM_ASSERT_IMPL(a_block_end_high, rsp_valid && last_of_block, last_of_byte, "block end flagged on a low-nibble sample")
   `ADPCM_ASSERT_NEXT(a_pair_follows, rsp_valid && rsp_ready && !last_of_byte, !req_ready, "new byte taken before high-nibble sample")

endmodule

bind adpcm_block_sample_decoder adpcm_dec_checker u_adpcm_dec_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .pcm_sample    (rsp_chan.pcm_sample),
   .last_of_byte  (rsp_chan.last_of_byte),
   .last_of_block (rsp_chan.last_of_block)
);
